@@ sv/rpwd_pkg.sv @@
// Shared widths, constants and the front-to-back operation record of the pulse width decoder.
package rpwd_pkg;

	localparam int CHAN_W  = 3;
	localparam int PULSE_W = 16;
	localparam int POS_W   = 8;
	localparam int AXIS_W  = 8;
	localparam int DZ_W    = 7;
	localparam int SPAN_W  = 10;   // clamped width minus 1000, 0..1000
	localparam int SCALED_W = 16;  // span * 51, at most 51000
	localparam int Z_W     = 13;   // scaled / 8, at most 6375
	localparam int PROD_W  = 27;   // z times reciprocal of 25
	localparam int QUOT_W  = 8;    // axis quotient, at most 254
	localparam int DIVD_W  = 15;   // (n +/- u) * 127, at most 32258
	localparam int TERM_W  = 8;    // n +/- u, at most 254

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [PULSE_W-1:0] LOST_LOW   = 16'd750;
	localparam logic [PULSE_W-1:0] LOST_HIGH  = 16'd2250;
	localparam logic [PULSE_W-1:0] CLAMP_LOW  = 16'd1000;
	localparam logic [PULSE_W-1:0] CLAMP_HIGH = 16'd2000;
	localparam logic [SCALED_W-1:0] SPAN_MUL  = 16'd51;      // 255/1000 = 51/200
	localparam logic [PROD_W-1:0]  RECIP_25   = 27'd10486;   // ceil(2^18 / 25)
	localparam int                 RECIP_SHIFT = 18;
	localparam logic [POS_W-1:0]   POS_CENTRE = 8'd127;
	localparam logic [POS_W-1:0]   POS_MAX    = 8'd255;
	localparam logic [DZ_W-1:0]    MAG_MAX    = 7'd127;

	// One classified item handed from the front to the divider.
	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [POS_W-1:0]  position;
		logic              signal_lost;
		logic              in_dead;     // axis forced to zero
		logic [DIVD_W-1:0] dividend;
		logic [DZ_W-1:0]   divisor;     // n = 127 - dead_zone
	} rpwd_op_t;

endpackage

@@ sv/rpwd_front.sv @@
// Front: accepts pulse beats, maps width to position and prepares the axis division.
module rpwd_front
	import rpwd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [DZ_W-1:0]     dead_zone,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CHAN_W-1:0]   channel,
	input  logic [PULSE_W-1:0]  pulse_us,
	output logic                out_valid,
	input  logic                out_ready,
	output rpwd_op_t            out_op
);

	logic                 lost_w;
	logic [PULSE_W-1:0]   clamp_w;
	logic [SPAN_W-1:0]    span_w;
	logic [SCALED_W-1:0]  scaled_w;

	logic                 v_s1;
	logic [CHAN_W-1:0]    ch_s1;
	logic                 lost_s1;
	logic [Z_W-1:0]       z_s1;

	logic [PROD_W-1:0]    prod_w;
	logic [POS_W-1:0]     pos_w;

	logic                 v_s2;
	logic [CHAN_W-1:0]    ch_s2;
	logic                 lost_s2;
	logic [POS_W-1:0]     pos_s2;

	logic                 rdy_s1;
	logic                 rdy_s2;

	logic                 neg_w;
	logic [DZ_W-1:0]      mag_w;
	logic [DZ_W-1:0]      n_w;
	logic [DZ_W-1:0]      u_w;
	logic [TERM_W-1:0]    term_w;

	// stall chain
	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// loss check, clamp and scale by 51 (255/1000 = 51/200)
	always_comb begin
		lost_w = (pulse_us < LOST_LOW) || (pulse_us > LOST_HIGH);
		priority if (pulse_us < CLAMP_LOW) begin
			clamp_w = CLAMP_LOW;
		end else if (pulse_us > CLAMP_HIGH) begin
			clamp_w = CLAMP_HIGH;
		end else begin
			clamp_w = pulse_us;
		end
		span_w   = SPAN_W'(clamp_w - CLAMP_LOW);
		scaled_w = SCALED_W'({{(SCALED_W-SPAN_W){1'b0}}, span_w} * SPAN_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ch_s1   <= channel;
			lost_s1 <= lost_w;
			z_s1    <= scaled_w[SCALED_W-1:3];
		end
	end

	// divide by 25 through reciprocal multiply
	assign prod_w = {{(PROD_W-Z_W){1'b0}}, z_s1} * RECIP_25;
	assign pos_w  = lost_s1 ? POS_CENTRE : prod_w[RECIP_SHIFT+POS_W-1:RECIP_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			ch_s2   <= ch_s1;
			lost_s2 <= lost_s1;
			pos_s2  <= pos_w;
		end
	end

	// centre, saturate, deadband and build (n +/- u) * 127 over n
	always_comb begin
		neg_w = pos_s2 < POS_CENTRE;
		priority if (neg_w) begin
			mag_w = DZ_W'(POS_CENTRE - pos_s2);
		end else if (pos_s2 == POS_MAX) begin
			mag_w = MAG_MAX;
		end else begin
			mag_w = DZ_W'(pos_s2 - POS_CENTRE);
		end
		n_w    = MAG_MAX - dead_zone;
		u_w    = mag_w - dead_zone;
		term_w = neg_w ? ({1'b0, n_w} - {1'b0, u_w}) : ({1'b0, n_w} + {1'b0, u_w});

		out_op.channel     = ch_s2;
		out_op.position    = pos_s2;
		out_op.signal_lost = lost_s2;
		out_op.in_dead     = mag_w <= dead_zone;
		out_op.dividend    = {term_w, 7'b0} - {7'b0, term_w};
		out_op.divisor     = n_w;
	end

	assign out_valid = v_s2;

endmodule

@@ sv/rpwd_queue.sv @@
// Short queue of classified operations between front and divider.
module rpwd_queue
	import rpwd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rpwd_op_t  in_op,
	output logic      out_valid,
	input  logic      out_ready,
	output rpwd_op_t  out_op
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rpwd_op_t           slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_op    = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_op;
		end
	end

endmodule

@@ sv/rpwd_back.sv @@
// Back: pipelined restoring divider, one quotient bit per stage, plus output register.
module rpwd_back
	import rpwd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rpwd_op_t            in_op,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CHAN_W-1:0]   channel_out,
	output logic [POS_W-1:0]    position,
	output logic [AXIS_W-1:0]   axis,
	output logic                signal_lost
);

	localparam int STEPS = QUOT_W;

	logic                 stage_v_s   [STEPS];
	rpwd_op_t             stage_op_s  [STEPS];
	logic [DIVD_W-1:0]    stage_rem_s [STEPS];
	logic [QUOT_W-1:0]    stage_quo_s [STEPS];
	logic                 stage_rdy   [STEPS+1];

	logic                 out_v_q;
	logic [CHAN_W-1:0]    chan_q;
	logic [POS_W-1:0]     pos_q;
	logic [AXIS_W-1:0]    axis_q;
	logic                 lost_q;
	logic [AXIS_W-1:0]    axis_w;

	assign stage_rdy[STEPS] = !out_v_q || out_ready;
	assign in_ready         = stage_rdy[0];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic              v_in;
		rpwd_op_t          op_in;
		logic [DIVD_W-1:0] rem_in;
		logic [QUOT_W-1:0] quo_in;
		logic [DIVD_W-1:0] sub_w;
		logic              take_w;

		if (k == 0) begin : g_head
			assign v_in   = in_valid;
			assign op_in  = in_op;
			assign rem_in = in_op.dividend;
			assign quo_in = '0;
		end else begin : g_link
			assign v_in   = stage_v_s[k-1];
			assign op_in  = stage_op_s[k-1];
			assign rem_in = stage_rem_s[k-1];
			assign quo_in = stage_quo_s[k-1];
		end

		assign stage_rdy[k] = !stage_v_s[k] || stage_rdy[k+1];

		// trial subtract of divisor aligned to this quotient bit
		assign sub_w  = {{(DIVD_W-DZ_W){1'b0}}, op_in.divisor} << (STEPS - 1 - k);
		assign take_w = rem_in >= sub_w;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_v_s[k] <= 1'b0;
			end else if (stage_rdy[k]) begin
				stage_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (stage_rdy[k] && v_in) begin
				stage_op_s[k]  <= op_in;
				stage_rem_s[k] <= take_w ? (rem_in - sub_w) : rem_in;
				stage_quo_s[k] <= quo_in | (QUOT_W'(take_w) << (STEPS - 1 - k));
			end
		end
	end

	// quotient minus 127 gives the signed axis
	assign axis_w = stage_op_s[STEPS-1].in_dead ? '0 : (stage_quo_s[STEPS-1] - POS_CENTRE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (stage_rdy[STEPS]) begin
			out_v_q <= stage_v_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[STEPS] && stage_v_s[STEPS-1]) begin
			chan_q <= stage_op_s[STEPS-1].channel;
			pos_q  <= stage_op_s[STEPS-1].position;
			lost_q <= stage_op_s[STEPS-1].signal_lost;
			axis_q <= axis_w;
		end
	end

	assign out_valid   = out_v_q;
	assign channel_out = chan_q;
	assign position    = pos_q;
	assign axis        = axis_q;
	assign signal_lost = lost_q;

endmodule

@@ sv/rc_pulse_width_decoder.sv @@
// Top level of the radio-control pulse width decoder.
// Takes one measured pulse width per beat and returns one result beat: position 0..255
// (127 with the loss flag when the width is outside 750..2250 us) and a signed stick axis
// with deadband rescale. One beat is accepted per clock when the output is drained. A beat
// passes two front stages (clamp and scale, reciprocal multiply), the operation queue,
// eight divider stages (one quotient bit each, dividing by 127 - dead_zone) and the output
// register. The queue lets the front keep accepting for a few beats while the output is
// stalled. dead_zone is written through cfg_we/cfg_wdata and should only change while no
// beat is in flight.
module rc_pulse_width_decoder
	import rpwd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [DZ_W-1:0]           cfg_wdata,   // dead_zone
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [PULSE_W-1:0]        s_tdata,     // [15:0] pulse_us
	input  logic [CHAN_W-1:0]         s_tuser,     // [2:0] channel
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [POS_W+AXIS_W-1:0]   m_tdata,     // [7:0] position, [15:8] axis
	output logic [CHAN_W:0]           m_tuser      // [2:0] channel_out, [3] signal_lost
);

	logic [DZ_W-1:0]    dead_zone_q;
	logic               fq_valid;
	logic               fq_ready;
	rpwd_op_t           fq_op;
	logic               qb_valid;
	logic               qb_ready;
	rpwd_op_t           qb_op;
	logic [CHAN_W-1:0]  chan_out_w;
	logic [POS_W-1:0]   pos_w;
	logic [AXIS_W-1:0]  axis_w;
	logic               lost_w;

	// deadband register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= '0;
		end else if (cfg_we) begin
			dead_zone_q <= cfg_wdata;
		end
	end

	rpwd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.dead_zone (dead_zone_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.channel   (s_tuser),
		.pulse_us  (s_tdata),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_op    (fq_op)
	);

	rpwd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_op     (fq_op),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_op    (qb_op)
	);

	rpwd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (qb_valid),
		.in_ready    (qb_ready),
		.in_op       (qb_op),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.channel_out (chan_out_w),
		.position    (pos_w),
		.axis        (axis_w),
		.signal_lost (lost_w)
	);

	assign m_tdata = {axis_w, pos_w};
	assign m_tuser = {lost_w, chan_out_w};

	// a lost signal always reports centre position and zero axis
	a_lost_centre: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[CHAN_W] |-> m_tdata[POS_W-1:0] == POS_CENTRE
			&& m_tdata[POS_W+AXIS_W-1:POS_W] == '0)
		else $error("lost signal result not centred");

	// saturation keeps the axis off the most negative code
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[POS_W+AXIS_W-1:POS_W] != {1'b1, {(AXIS_W-1){1'b0}}})
		else $error("axis out of range");

	// full deadband flattens every axis
	a_full_dead: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dead_zone_q == MAG_MAX |-> m_tdata[POS_W+AXIS_W-1:POS_W] == '0)
		else $error("axis not zero with full deadband");

endmodule
